// ----- rtl/core/kcwd_pkg.sv -----
package kcwd_pkg;

    localparam int KEY_WORDS     = 16;
    localparam int KEYFILE_WORDS = 128;
    localparam int KEY_IDX_W     = $clog2(KEY_WORDS);
    localparam int KF_IDX_W      = $clog2(KEYFILE_WORDS);
    localparam int WORD_W        = 64;
    localparam int OPCODE_W      = 2;

    // fixed key table entries used by a start item
    localparam logic [KEY_IDX_W-1:0] START_CHAIN_IDX = KEY_IDX_W'(3);
    localparam logic [KEY_IDX_W-1:0] MODE0_POS_IDX   = KEY_IDX_W'(6);
    localparam logic [KEY_IDX_W-1:0] MODE1_POS_IDX   = KEY_IDX_W'(4);
    localparam logic [3:0]           MODE1_POS_MASK  = 4'hD;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD_KEY     = 2'd0,
        OP_LOAD_KEYFILE = 2'd1,
        OP_START        = 2'd2,
        OP_DATA         = 2'd3
    } t_opcode;

    typedef enum logic {
        MODE_KEY_ONLY    = 1'b0,
        MODE_KEY_KEYFILE = 1'b1
    } t_mode;

    typedef struct packed {
        t_opcode             opcode;
        logic [KF_IDX_W-1:0] idx;
        logic [WORD_W-1:0]   word;
    } t_item;

    typedef struct packed {
        logic                key_we;
        logic                kf_we;
        logic [KF_IDX_W-1:0] idx;
        logic [WORD_W-1:0]   data;
    } t_tbl_wr;

    typedef struct packed {
        logic [WORD_W-1:0] chain_seed;
        logic [3:0]        mode0_pos;
        logic [3:0]        mode1_pos;
    } t_key_taps;

endpackage

// ----- rtl/core/kcwd_ifs.sv -----
interface kcwd_in_if;
    logic                                valid;
    logic                                ready;
    logic [kcwd_pkg::OPCODE_W-1:0]       opcode;
    logic [kcwd_pkg::KF_IDX_W-1:0]       table_index;
    logic [kcwd_pkg::WORD_W-1:0]         word_value;

    modport source (output valid, output opcode, output table_index, output word_value,
                    input ready);
    modport sink   (input valid, input opcode, input table_index, input word_value,
                    output ready);
endinterface

interface kcwd_out_if;
    logic                        valid;
    logic                        ready;
    logic [kcwd_pkg::WORD_W-1:0] plain_word;

    modport source (output valid, output plain_word, input ready);
    modport sink   (input valid, input plain_word, output ready);
endinterface

interface kcwd_cfg_if;
    logic valid;
    logic ready;
    logic cipher_mode;

    modport source (output valid, output cipher_mode, input ready);
    modport sink   (input valid, input cipher_mode, output ready);
endinterface

// ----- rtl/core/keyed_chain_word_decrypt.sv -----
// keyed chain word decrypter
// i_in carries one word per handshake: opcode, table_index and word_value.
// load-key and load-keyfile words fill the 16-entry key table and the
// 128-entry keyfile table, a start word seeds the chain and the position,
// and each data word gives one plain word on o_out.
// i_cfg writes cipher_mode (key only, or key xor keyfile); it is always
// ready and is meant to be written only while the block is idle.
// a data word accepted into the input register is decrypted there and
// registered into the output register, from which it shows on o_out.
// throughput is one word per cycle while o_out does not stall, set by the
// chain update; the keyfile word is prefetched at the next position.
// loads and start words give no output word.
// reset clears the chain, the position, cipher_mode and both valid flags;
// the tables are not cleared and must be loaded before use.
// when o_out stalls, one plain word waits in the output register and the
// input register still takes one more word; loads and start words keep
// flowing past a stalled output.
module keyed_chain_word_decrypt (
    input  logic         i_clk,
    input  logic         i_rst_n,
    kcwd_in_if.sink      i_in,
    kcwd_cfg_if.sink     i_cfg,
    kcwd_out_if.source   o_out
);
    import kcwd_pkg::*;

    logic                r_in_valid;
    t_item               r_item;
    t_mode               r_mode;
    logic                fire;
    logic                out_free;
    t_tbl_wr             tbl_wr;
    t_key_taps           taps;
    logic [WORD_W-1:0]   key_word;
    logic [WORD_W-1:0]   keyfile_word;
    logic [KF_IDX_W-1:0] pos;
    logic [KF_IDX_W-1:0] n_pos;

    assign fire       = r_in_valid && ((r_item.opcode != OP_DATA) || out_free);
    assign i_in.ready = !r_in_valid || fire;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_KEY_ONLY;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (i_cfg.valid) begin
                r_mode <= t_mode'(i_cfg.cipher_mode);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.opcode <= t_opcode'(i_in.opcode);
            r_item.idx    <= i_in.table_index;
            r_item.word   <= i_in.word_value;
        end
    end

    always_comb begin
        tbl_wr.key_we = fire && (r_item.opcode == OP_LOAD_KEY);
        tbl_wr.kf_we  = fire && (r_item.opcode == OP_LOAD_KEYFILE);
        tbl_wr.idx    = r_item.idx;
        tbl_wr.data   = r_item.word;
    end

    kcwd_tables u_tables (
        .i_clk     (i_clk),
        .i_wr      (tbl_wr),
        .i_pos     (pos),
        .i_n_pos   (n_pos),
        .o_key     (key_word),
        .o_keyfile (keyfile_word),
        .o_taps    (taps)
    );

    kcwd_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_item),
        .i_mode      (r_mode),
        .i_key       (key_word),
        .i_keyfile   (keyfile_word),
        .i_taps      (taps),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_plain     (o_out.plain_word),
        .o_out_free  (out_free),
        .o_pos       (pos),
        .o_n_pos     (n_pos)
    );

    a_data_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (r_item.opcode == OP_DATA) |=> o_out.valid)
        else $error("data word processed but no output word");

    a_ctrl_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (r_item.opcode != OP_DATA) && !o_out.valid |=> !o_out.valid)
        else $error("output word from a load or start word");

    a_mode0_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (r_item.opcode == OP_DATA) && (r_mode == MODE_KEY_ONLY)
        |=> pos[KF_IDX_W-1:KEY_IDX_W] == '0)
        else $error("key-only position left the key table range");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_in_valid && (r_item.opcode == OP_DATA) && !out_free)
        else $error("input stalled without a blocked data word");

endmodule

// ----- rtl/core/kcwd_tables.sv -----
module kcwd_tables (
    input  logic                               i_clk,
    input  kcwd_pkg::t_tbl_wr                  i_wr,
    input  logic [kcwd_pkg::KF_IDX_W-1:0]      i_pos,
    input  logic [kcwd_pkg::KF_IDX_W-1:0]      i_n_pos,
    output logic [kcwd_pkg::WORD_W-1:0]        o_key,
    output logic [kcwd_pkg::WORD_W-1:0]        o_keyfile,
    output kcwd_pkg::t_key_taps                o_taps
);
    import kcwd_pkg::*;

    logic [WORD_W-1:0] r_key [KEY_WORDS];
    logic [WORD_W-1:0] r_kf_mem [KEYFILE_WORDS];
    logic [WORD_W-1:0] r_kf_rd;
    logic              r_kf_byp;
    logic [WORD_W-1:0] r_kf_byp_data;
    logic [WORD_W-1:0] mode0_word;
    logic [WORD_W-1:0] mode1_word;

    always_ff @(posedge i_clk) begin
        if (i_wr.key_we) begin
            r_key[i_wr.idx[KEY_IDX_W-1:0]] <= i_wr.data;
        end
    end

    // keyfile word is prefetched into a register at the position the chain moves to
    always_ff @(posedge i_clk) begin
        if (i_wr.kf_we) begin
            r_kf_mem[i_wr.idx] <= i_wr.data;
        end
        r_kf_rd       <= r_kf_mem[i_n_pos];
        r_kf_byp      <= i_wr.kf_we && (i_wr.idx == i_n_pos);
        r_kf_byp_data <= i_wr.data;
    end

    assign o_keyfile = r_kf_byp ? r_kf_byp_data : r_kf_rd;
    assign o_key     = r_key[i_pos[KEY_IDX_W-1:0]];

    assign mode0_word = r_key[MODE0_POS_IDX];
    assign mode1_word = r_key[MODE1_POS_IDX];

    always_comb begin
        o_taps.chain_seed = r_key[START_CHAIN_IDX];
        o_taps.mode0_pos  = mode0_word[35:32];
        o_taps.mode1_pos  = mode1_word[3:0];
    end

endmodule

// ----- rtl/core/kcwd_step.sv -----
module kcwd_step (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_fire,
    input  kcwd_pkg::t_item                    i_item,
    input  kcwd_pkg::t_mode                    i_mode,
    input  logic [kcwd_pkg::WORD_W-1:0]        i_key,
    input  logic [kcwd_pkg::WORD_W-1:0]        i_keyfile,
    input  kcwd_pkg::t_key_taps                i_taps,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [kcwd_pkg::WORD_W-1:0]        o_plain,
    output logic                               o_out_free,
    output logic [kcwd_pkg::KF_IDX_W-1:0]      o_pos,
    output logic [kcwd_pkg::KF_IDX_W-1:0]      o_n_pos
);
    import kcwd_pkg::*;

    logic [WORD_W-1:0]   r_chain;
    logic [WORD_W-1:0]   n_chain;
    logic [KF_IDX_W-1:0] r_pos;
    logic [KF_IDX_W-1:0] n_pos;
    logic                r_out_valid;
    logic                n_out_valid;
    logic [WORD_W-1:0]   r_plain;

    logic [WORD_W-1:0]   k;
    logic [WORD_W-1:0]   c_xor;
    logic [WORD_W-1:0]   c_lane;
    logic [WORD_W-1:0]   plain;
    logic [WORD_W-1:0]   c_byte;
    logic [WORD_W-1:0]   c_mix;
    logic [WORD_W-1:0]   c_shl;
    logic [WORD_W-1:0]   c_half;
    logic [3:0]          pos_lo_inc;

    assign k     = (i_mode == MODE_KEY_KEYFILE) ? (i_key ^ i_keyfile) : i_key;
    assign c_xor = r_chain ^ k;
    assign c_lane = {c_xor[63:32] + k[63:32], c_xor[31:0] + k[31:0]};
    assign plain = i_item.word ^ c_lane;

    always_comb begin
        for (int b = 0; b < WORD_W / 8; b++) begin
            c_byte[8*b +: 8] = c_lane[8*b +: 8] + plain[8*b +: 8];
        end
    end

    assign c_mix = c_byte ^ plain;
    // each 32-bit lane shifts left by one, bits do not cross lanes
    assign c_shl = {c_mix[62:32], 1'b0, c_mix[30:0], 1'b0};

    always_comb begin
        for (int h = 0; h < WORD_W / 16; h++) begin
            c_half[16*h +: 16] = c_shl[16*h +: 16] + plain[16*h +: 16];
        end
    end

    assign pos_lo_inc = r_pos[3:0] + 4'd1;

    always_comb begin
        n_chain = r_chain;
        n_pos   = r_pos;
        if (i_fire) begin
            case (i_item.opcode)
                OP_START: begin
                    n_chain = i_taps.chain_seed;
                    if (i_mode == MODE_KEY_KEYFILE) begin
                        n_pos = {i_taps.mode1_pos & MODE1_POS_MASK, 3'b000};
                    end else begin
                        n_pos = {3'b000, i_taps.mode0_pos};
                    end
                end
                OP_DATA: begin
                    n_chain = c_half;
                    if (i_mode == MODE_KEY_KEYFILE) begin
                        n_pos = r_pos + KF_IDX_W'(1);
                    end else begin
                        n_pos = {3'b000, pos_lo_inc};
                    end
                end
                default: begin
                    n_chain = r_chain;
                    n_pos   = r_pos;
                end
            endcase
        end
    end

    assign o_out_free  = !r_out_valid || i_out_ready;
    assign n_out_valid = (i_fire && (i_item.opcode == OP_DATA)) ||
                         (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain     <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_chain     <= n_chain;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && (i_item.opcode == OP_DATA)) begin
            r_plain <= plain;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_plain     = r_plain;
    assign o_pos       = r_pos;
    assign o_n_pos     = n_pos;

endmodule
